### src/wbps_pkg.sv
package wbps_pkg;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_PATTERN_BYTES = 32;
  localparam int DEF_ADDRESS_BITS      = 48;

  // Fixed field widths and sizes of the ports and configuration registers.
  localparam int IN_TDATA_W    = 8;
  localparam int OUT_ADDR_BITS = 48;
  localparam int OUT_TDATA_W   = 48;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int WILDCARD_W    = 32;
  localparam int PAT_LEN_W     = 6;
  localparam int PAT_WORDS     = 4;
  localparam int PAT_SLOTS     = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_0_7   = 3'd0,
    CFG_PATTERN_8_15  = 3'd1,
    CFG_PATTERN_16_23 = 3'd2,
    CFG_PATTERN_24_31 = 3'd3,
    CFG_WILDCARD_MASK = 3'd4,
    CFG_PATTERN_LEN   = 3'd5,
    CFG_RESULT_OFFSET = 3'd6,
    CFG_REGION_BASE   = 3'd7
  } cfg_idx_t;

endpackage

### src/wildcard_byte_pattern_search.sv
// Wildcard byte pattern search. The block takes one byte of a memory region
// per word on the input stream (tlast marks the final byte of the region) and
// looks for the first place where the configured pattern of up to
// MAX_PATTERN_BYTES bytes matches, with a per-position wildcard bit that lets
// a pattern byte match anything. On the first match it returns one word with
// tuser (found) set and tdata holding region_base + match start +
// result_offset, modulo 2^ADDRESS_BITS, and then ignores the rest of the
// region. A region that ends without a match returns one word with found
// clear and a zero address; a region that already reported returns nothing at
// its end. The search state clears after every last byte, so matches are found
// anywhere in the region but never across two regions. The block accepts one
// byte per clock cycle; its result passes the input register and then the
// result register on the way out. The whole window compare of all pattern
// positions is combinational between the input and result registers; the
// input only stalls while a result word waits in the output register and the
// sink holds tready low. Write the configuration registers only while no
// byte is in flight; a write lands at the clock edge at which cfg_we is high.
module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = wbps_pkg::DEF_MAX_PATTERN_BYTES,
  parameter int ADDRESS_BITS      = wbps_pkg::DEF_ADDRESS_BITS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream: tdata[7:0] = data_byte, tlast = last_byte.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [wbps_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tlast,
  // Result stream: tdata[47:0] = match_address, tuser[0] = found.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [wbps_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tuser,
  // Configuration write port.
  input  logic                             cfg_we,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import wbps_pkg::*;

  localparam int D     = MAX_PATTERN_BYTES;
  localparam int AW    = ADDRESS_BITS;
  localparam int IDX_W = (D > 1) ? $clog2(D) : 1;
  localparam int EXT_W = (AW > OUT_ADDR_BITS) ? AW : OUT_ADDR_BITS;

  // Configuration registers.
  logic [CFG_DATA_W-1:0] pat_word_r [PAT_WORDS];
  logic [WILDCARD_W-1:0] wildcard_r;
  logic [PAT_LEN_W-1:0]  pat_len_r;
  logic [OUT_ADDR_BITS-1:0] offset_r;
  logic [OUT_ADDR_BITS-1:0] base_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Region state. The window contents need no reset: fill_r says how many
  // entries are valid and the compare only looks at valid ones.
  logic [7:0]           win_r [D];
  logic [PAT_LEN_W-1:0] fill_r;
  logic [AW-1:0]        index_r;
  logic                 reported_r;

  // Result register.
  logic                     out_valid_r;
  logic                     found_r;
  logic [OUT_ADDR_BITS-1:0] addr_r;

  // Handshakes.
  logic in_fire;
  logic s1_adv;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  // Compare logic.
  logic [7:0]           pat_byte [PAT_SLOTS];
  logic [7:0]           new_win  [D];
  logic [PAT_LEN_W-1:0] len_eff;
  logic [PAT_LEN_W-1:0] age      [D];
  logic [D-1:0]         hit;
  logic [PAT_LEN_W-1:0] fill_nxt;
  logic                 match;
  logic                 res_valid;
  logic                 res_found;
  logic [AW-1:0]        start_addr;
  logic [AW-1:0]        sum_addr;
  logic [EXT_W-1:0]     addr_ext;
  logic [OUT_ADDR_BITS-1:0] res_addr;

  always_comb begin
    for (int w = 0; w < PAT_WORDS; w++) begin
      for (int k = 0; k < 8; k++) begin
        pat_byte[w*8+k] = pat_word_r[w][k*8 +: 8];
      end
    end
  end

  // Length zero behaves as one, anything past the window as the full window.
  always_comb begin
    if (pat_len_r == '0) begin
      len_eff = PAT_LEN_W'(1);
    end else if (pat_len_r > PAT_LEN_W'(D)) begin
      len_eff = PAT_LEN_W'(D);
    end else begin
      len_eff = pat_len_r;
    end
  end

  // Window as it stands after the byte in the input register shifts in.
  always_comb begin
    new_win[0] = s1_byte_r;
    for (int k = 1; k < D; k++) begin
      new_win[k] = win_r[k-1];
    end
  end

  // Pattern byte i lines up with the window byte of age len - 1 - i.
  always_comb begin
    for (int i = 0; i < D; i++) begin
      age[i] = len_eff - PAT_LEN_W'(i) - PAT_LEN_W'(1);
      hit[i] = (PAT_LEN_W'(i) >= len_eff) || wildcard_r[i] ||
               (new_win[age[i][IDX_W-1:0]] == pat_byte[i]);
    end
  end

  assign fill_nxt = (fill_r < PAT_LEN_W'(D)) ? fill_r + PAT_LEN_W'(1) : fill_r;
  assign match    = !reported_r && (fill_nxt >= len_eff) && (&hit);

  assign start_addr = index_r - AW'(len_eff) + AW'(1);
  assign sum_addr   = AW'(base_r) + start_addr + AW'(offset_r);
  assign addr_ext   = EXT_W'(sum_addr);

  always_comb begin
    res_valid = 1'b0;
    res_found = 1'b0;
    res_addr  = '0;
    if (match) begin
      res_valid = 1'b1;
      res_found = 1'b1;
      res_addr  = addr_ext[OUT_ADDR_BITS-1:0];
    end else if (s1_last_r && !reported_r) begin
      res_valid = 1'b1;
    end
  end

  // Configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < PAT_WORDS; w++) begin
        pat_word_r[w] <= '0;
      end
      wildcard_r <= '0;
      pat_len_r  <= PAT_LEN_W'(1);
      offset_r   <= '0;
      base_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_PATTERN_0_7:   pat_word_r[0] <= cfg_wdata;
        CFG_PATTERN_8_15:  pat_word_r[1] <= cfg_wdata;
        CFG_PATTERN_16_23: pat_word_r[2] <= cfg_wdata;
        CFG_PATTERN_24_31: pat_word_r[3] <= cfg_wdata;
        CFG_WILDCARD_MASK: wildcard_r    <= cfg_wdata[WILDCARD_W-1:0];
        CFG_PATTERN_LEN:   pat_len_r     <= cfg_wdata[PAT_LEN_W-1:0];
        CFG_RESULT_OFFSET: offset_r      <= cfg_wdata[OUT_ADDR_BITS-1:0];
        CFG_REGION_BASE:   base_r        <= cfg_wdata[OUT_ADDR_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Region state advances when the byte in the input register is consumed.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int k = 0; k < D; k++) begin
        win_r[k] <= new_win[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      index_r    <= '0;
      reported_r <= 1'b0;
    end else if (s1_adv) begin
      if (s1_last_r) begin
        fill_r     <= '0;
        index_r    <= '0;
        reported_r <= 1'b0;
      end else begin
        fill_r     <= fill_nxt;
        index_r    <= index_r + AW'(1);
        reported_r <= reported_r || match;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      found_r <= res_found;
      addr_r  <= res_addr;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = found_r;
  assign out_tdata  = addr_r;

  // A region that has already reported never produces a second word.
  a_no_second_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && reported_r) |-> !res_valid)
    else $error("second result in one region");

  // A miss always carries a zero address.
  a_miss_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !found_r) |-> (addr_r == '0))
    else $error("miss word with nonzero address");

  // Consuming the last byte of a region leaves a cleared state.
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_last_r) |=> (fill_r == '0 && index_r == '0 && !reported_r))
    else $error("state not cleared after last byte");

  // The fill count never runs past the window depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= PAT_LEN_W'(D))
    else $error("window fill beyond depth");

endmodule
